// ===== design/mvm_pkg.sv =====
// Shared types, constants and helpers for the matrix-vector multiplier.
package mvm_pkg;

  localparam int MAX_DIM       = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int FRAC_BITS     = 16;
  localparam int ACC_W         = 64;
  localparam int OUT_W         = 32;
  localparam int CFG_W         = 5;
  localparam int IDX_W         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W         = $clog2(MAX_DIM + 1);
  localparam int ADDR_W        = 2 * IDX_W;
  localparam int MAT_DEPTH     = 1 << ADDR_W;
  localparam int SH_W          = ACC_W - FRAC_BITS;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROW_COUNT    = 1'b0;
  localparam cfg_idx_t CFG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         row_index;
    logic [3:0]         column_index;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_row;
    logic signed [31:0] product;
    logic               end_of_run;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_EMIT_DRAIN
  } state_t;

  function automatic logic [CNT_W-1:0] size_in_use(input logic [CFG_W-1:0] size_reg);
    logic [CNT_W-1:0] n;
    if (size_reg == '0) begin
      n = CNT_W'(1);
    end else if (int'(size_reg) > MAX_DIM) begin
      n = CNT_W'(MAX_DIM);
    end else begin
      n = CNT_W'(size_reg);
    end
    return n;
  endfunction

endpackage

// ===== design/matrix_vector_multiply.sv =====
// Top level of the Q16.16 dense matrix-vector multiplier.
//
// A matrix element beat (mode 0) is written in the cycle it is accepted and
// busy stays low. A vector element beat (mode 1) walks the rows in use through
// one shared multiply-accumulate: one row per cycle reads the matrix memory
// and the accumulator memory, multiplies, adds with 64-bit saturation and
// writes back, with busy high until the last row is written. A vector beat with
// last set then reads the accumulators back, one row per cycle, and presents
// one result per row in row order on result with result_valid high for a
// single cycle each; results cannot be held off. The accumulators are cleared
// when emission ends. Matrix beats whose indices, and vector beats whose column
// index, fall outside the sizes in use are dropped. Write row_count and
// column_count only while busy is low.
module matrix_vector_multiply (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  mvm_pkg::item_t             item,
  output logic                       result_valid,
  output mvm_pkg::result_t           result,
  input  logic                       cfg_write,
  input  mvm_pkg::cfg_idx_t          cfg_index,
  input  logic [mvm_pkg::CFG_W-1:0]  cfg_data
);

  mvm_pkg::state_t state;
  mvm_pkg::state_t state_next;

  logic [mvm_pkg::CFG_W-1:0]  row_count;
  logic [mvm_pkg::CFG_W-1:0]  column_count;
  logic [mvm_pkg::CNT_W-1:0]  rows;
  logic [mvm_pkg::CNT_W-1:0]  cols;

  logic accept;
  logic row_in_range;
  logic col_in_range;
  logic mat_wr;
  logic vec_go;

  logic signed [mvm_pkg::ELEMENT_WIDTH-1:0] x_val;
  logic [mvm_pkg::IDX_W-1:0]                col_q;
  logic                                     last_q;

  logic [mvm_pkg::CNT_W-1:0] cnt;
  logic                      last_issue;
  logic                      issue_mac;
  logic                      issue_emit;
  logic                      cnt_clear;
  logic                      acc_clear;

  logic [mvm_pkg::MAT_DEPTH-1:0]     mat_valid;
  logic [mvm_pkg::ADDR_W-1:0]        mat_waddr;
  logic [mvm_pkg::ADDR_W-1:0]        mat_raddr;
  logic [mvm_pkg::ELEMENT_WIDTH-1:0] mat_rdata;
  logic                              mat_vld_q;

  logic [mvm_pkg::MAX_DIM-1:0] acc_valid;
  logic [mvm_pkg::IDX_W-1:0]   acc_raddr;
  logic [mvm_pkg::ACC_W-1:0]   acc_rdata;
  logic                        acc_vld_q;
  logic [mvm_pkg::ACC_W-1:0]   acc_cur;

  logic                                       s1_valid;
  logic [mvm_pkg::IDX_W-1:0]                  s1_row;
  logic signed [mvm_pkg::ELEMENT_WIDTH-1:0]   a_el;
  logic signed [2*mvm_pkg::ELEMENT_WIDTH-1:0] prod;

  logic                             s2_valid;
  logic [mvm_pkg::IDX_W-1:0]        s2_row;
  logic signed [mvm_pkg::ACC_W-1:0] s2_prod;
  logic [mvm_pkg::ACC_W:0]          sum_wide;
  logic [mvm_pkg::ACC_W-1:0]        acc_sat;

  logic                      e1_valid;
  logic [mvm_pkg::IDX_W-1:0] e1_row;
  logic                      e1_end;
  logic [mvm_pkg::SH_W-1:0]  sh;
  logic                      out_ovf;
  logic [mvm_pkg::OUT_W-1:0] q_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= mvm_pkg::CFG_W'(mvm_pkg::MAX_DIM);
      column_count <= mvm_pkg::CFG_W'(mvm_pkg::MAX_DIM);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mvm_pkg::CFG_ROW_COUNT:    row_count    <= cfg_data;
        mvm_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows = mvm_pkg::size_in_use(row_count);
  assign cols = mvm_pkg::size_in_use(column_count);

  // input beat decode
  assign busy         = (state != mvm_pkg::ST_IDLE);
  assign accept       = start && !busy;
  assign row_in_range = 8'(item.row_index) < 8'(rows);
  assign col_in_range = 8'(item.column_index) < 8'(cols);
  assign mat_wr       = accept && (item.mode == mvm_pkg::MODE_MATRIX) &&
                        row_in_range && col_in_range;
  assign vec_go       = accept && (item.mode == mvm_pkg::MODE_VECTOR) && col_in_range;

  always_ff @(posedge clk) begin
    if (vec_go) begin
      x_val  <= item.value[mvm_pkg::ELEMENT_WIDTH-1:0];
      col_q  <= mvm_pkg::IDX_W'(item.column_index);
      last_q <= item.last;
    end
  end

  // sequencer
  assign last_issue = (cnt + 1'b1) == rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue_mac  = 1'b0;
    issue_emit = 1'b0;
    cnt_clear  = 1'b0;
    acc_clear  = 1'b0;
    unique case (state)
      mvm_pkg::ST_IDLE: begin
        cnt_clear = 1'b1;
        if (vec_go) begin
          state_next = mvm_pkg::ST_MAC;
        end
      end
      mvm_pkg::ST_MAC: begin
        issue_mac = 1'b1;
        if (last_issue) begin
          state_next = mvm_pkg::ST_DRAIN;
        end
      end
      mvm_pkg::ST_DRAIN: begin
        cnt_clear = 1'b1;
        if (!s1_valid && !s2_valid) begin
          state_next = last_q ? mvm_pkg::ST_EMIT : mvm_pkg::ST_IDLE;
        end
      end
      mvm_pkg::ST_EMIT: begin
        issue_emit = 1'b1;
        if (last_issue) begin
          state_next = mvm_pkg::ST_EMIT_DRAIN;
        end
      end
      mvm_pkg::ST_EMIT_DRAIN: begin
        if (!e1_valid) begin
          acc_clear  = 1'b1;
          state_next = mvm_pkg::ST_IDLE;
        end
      end
      default: state_next = mvm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cnt_clear) begin
      cnt <= '0;
    end else if (issue_mac || issue_emit) begin
      cnt <= cnt + 1'b1;
    end
  end

  // matrix memory
  assign mat_waddr = {mvm_pkg::IDX_W'(item.row_index), mvm_pkg::IDX_W'(item.column_index)};
  assign mat_raddr = {cnt[mvm_pkg::IDX_W-1:0], col_q};

  mvm_ram #(
    .WIDTH(mvm_pkg::ELEMENT_WIDTH),
    .DEPTH(mvm_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk  (clk),
    .we   (mat_wr),
    .waddr(mat_waddr),
    .wdata(item.value[mvm_pkg::ELEMENT_WIDTH-1:0]),
    .raddr(mat_raddr),
    .rdata(mat_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid <= '0;
    end else if (mat_wr) begin
      mat_valid[mat_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mat_vld_q <= mat_valid[mat_raddr];
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue_mac;
      s2_valid <= s1_valid;
    end
  end

  assign a_el = mat_vld_q ? $signed(mat_rdata) : '0;
  assign prod = a_el * x_val;

  always_ff @(posedge clk) begin
    s1_row  <= cnt[mvm_pkg::IDX_W-1:0];
    s2_row  <= s1_row;
    s2_prod <= mvm_pkg::ACC_W'(prod);
  end

  // accumulator memory
  assign acc_raddr = issue_emit ? cnt[mvm_pkg::IDX_W-1:0] : s1_row;

  mvm_ram #(
    .WIDTH(mvm_pkg::ACC_W),
    .DEPTH(mvm_pkg::MAX_DIM)
  ) u_acc_ram (
    .clk  (clk),
    .we   (s2_valid),
    .waddr(s2_row),
    .wdata(acc_sat),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || acc_clear) begin
      acc_valid <= '0;
    end else if (s2_valid) begin
      acc_valid[s2_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_vld_q <= acc_valid[acc_raddr];
  end

  assign acc_cur = acc_vld_q ? acc_rdata : '0;

  // saturating accumulate
  assign sum_wide = {acc_cur[mvm_pkg::ACC_W-1], acc_cur} +
                    {s2_prod[mvm_pkg::ACC_W-1], s2_prod};
  assign acc_sat  = (sum_wide[mvm_pkg::ACC_W] != sum_wide[mvm_pkg::ACC_W-1]) ?
                    (sum_wide[mvm_pkg::ACC_W] ? mvm_pkg::ACC_MIN : mvm_pkg::ACC_MAX) :
                    sum_wide[mvm_pkg::ACC_W-1:0];

  // emission
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      e1_valid     <= issue_emit;
      result_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    e1_row <= cnt[mvm_pkg::IDX_W-1:0];
    e1_end <= last_issue;
  end

  assign sh      = acc_cur[mvm_pkg::ACC_W-1:mvm_pkg::FRAC_BITS];
  assign out_ovf = sh[mvm_pkg::SH_W-1:mvm_pkg::OUT_W-1] !=
                   {(mvm_pkg::SH_W-mvm_pkg::OUT_W+1){sh[mvm_pkg::SH_W-1]}};
  assign q_sat   = out_ovf ? (sh[mvm_pkg::SH_W-1] ? mvm_pkg::OUT_MIN : mvm_pkg::OUT_MAX) :
                   sh[mvm_pkg::OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (e1_valid) begin
      result.out_row    <= 4'(e1_row);
      result.product    <= q_sat;
      result.end_of_run <= e1_end;
    end
  end

  // checks
  a_no_mat_write_in_mac: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> !mat_wr)
    else $error("matrix write during multiply-accumulate");

  a_rmw_rows_differ: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_row != s2_row))
    else $error("accumulator read and write hit the same row");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.end_of_run) |=> !result_valid)
    else $error("result beat after end of run");

  a_idle_is_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mvm_pkg::ST_IDLE) |-> (!s1_valid && !s2_valid && !e1_valid))
    else $error("pipeline busy while idle");

  a_no_mac_during_emit: assert property (@(posedge clk) disable iff (rst)
    e1_valid |-> (!s1_valid && !s2_valid))
    else $error("accumulate overlaps emission");

endmodule

// ===== design/mvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for matrix_vector_multiply: directed and random beats checked against a Q16.16 model.
`timescale 1ns / 1ps

module tb;
  import mvm_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     SETTLE      = 40;
  localparam longint ACC_TOP     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_BOTTOM  = 64'sh8000_0000_0000_0000;
  localparam longint Q_TOP       = 64'sd2147483647;
  localparam longint Q_BOTTOM    = -64'sd2147483648;

  class mvm_scoreboard;
    bit [CFG_W-1:0]     rows_reg;
    bit [CFG_W-1:0]     cols_reg;
    logic signed [31:0] matrix [MAX_DIM][MAX_DIM];
    longint             row_sum [MAX_DIM];
    result_t            products_due [$];
    int                 failures;

    function new();
      rows_reg = 5'd16;
      cols_reg = 5'd16;
      failures = 0;
      foreach (matrix[i, j]) matrix[i][j] = '0;
      foreach (row_sum[i]) row_sum[i] = 0;
    endfunction

    function int dim(bit [CFG_W-1:0] size_reg);
      if (size_reg == 0) return 1;
      if (size_reg > MAX_DIM) return MAX_DIM;
      return int'(size_reg);
    endfunction

    function void set_size(cfg_idx_t idx, bit [CFG_W-1:0] data);
      if (idx == CFG_ROW_COUNT) rows_reg = data;
      else cols_reg = data;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // Returns 1 when the beat is taken, 0 when it is dropped as out of range.
    function bit take_item(item_t it);
      int      rows;
      int      cols;
      longint  p;
      longint  s;
      longint  q;
      result_t r;
      rows = dim(rows_reg);
      cols = dim(cols_reg);
      if (it.mode == MODE_MATRIX) begin
        if (it.row_index >= rows || it.column_index >= cols) return 0;
        matrix[it.row_index][it.column_index] = it.value;
        return 1;
      end
      if (it.column_index >= cols) return 0;
      for (int i = 0; i < rows; i++) begin
        p = longint'(matrix[i][it.column_index]) * longint'($signed(it.value));
        s = row_sum[i] + p;
        if (row_sum[i][63] == p[63] && s[63] != p[63]) s = p[63] ? ACC_BOTTOM : ACC_TOP;
        row_sum[i] = s;
      end
      if (it.last) begin
        for (int i = 0; i < rows; i++) begin
          q = row_sum[i] >>> FRAC_BITS;
          if (q > Q_TOP) q = Q_TOP;
          else if (q < Q_BOTTOM) q = Q_BOTTOM;
          r.out_row    = 4'(i);
          r.product    = q[31:0];
          r.end_of_run = (i == rows - 1);
          products_due.push_back(r);
        end
        foreach (row_sum[i]) row_sum[i] = 0;
      end
      return 1;
    endfunction

    function void check_product(result_t got);
      result_t want;
      if (products_due.size() == 0) begin
        report($sformatf("unexpected product: row %0d value %h end %0d",
                         got.out_row, got.product, got.end_of_run));
        return;
      end
      want = products_due.pop_front();
      if (got.out_row !== want.out_row || got.product !== want.product ||
          got.end_of_run !== want.end_of_run)
        report($sformatf({"product mismatch: expected row %0d value %h end %0d, ",
                          "got row %0d value %h end %0d"},
                         want.out_row, want.product, want.end_of_run,
                         got.out_row, got.product, got.end_of_run));
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  item_t          item;
  logic           result_valid;
  result_t        result;
  logic           cfg_write;
  cfg_idx_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mvm_scoreboard sb;
  int            idle_pct;
  int            items_done;
  int            cycle_count;

  matrix_vector_multiply dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_product(result);
  end

  function automatic item_t mk(logic m, int r, int c, logic [31:0] v, logic l);
    item_t it;
    it.mode         = m;
    it.row_index    = 4'(r);
    it.column_index = 4'(c);
    it.value        = v;
    it.last         = l;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = '0;
      3: v = 32'hFFFF_FFFF;
      4: v = 32'h0001_0000;
      5, 6: v = $urandom_range(0, 32'h7FFFF) - 32'h40000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int pick_index(int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, MAX_DIM - 1);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic send_item(item_t it);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    items_done += sb.take_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.products_due.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sizes(bit [CFG_W-1:0] rows, bit [CFG_W-1:0] cols);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rows;
    @(posedge clk);
    sb.set_size(CFG_ROW_COUNT, rows);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= cols;
    @(posedge clk);
    sb.set_size(CFG_COLUMN_COUNT, cols);
    cfg_write <= 1'b0;
  endtask

  task automatic run_sequence();
    int rows;
    int cols;
    rows = sb.dim(sb.rows_reg);
    cols = sb.dim(sb.cols_reg);
    if ($urandom_range(0, 9) == 0)
      send_item(mk(1'($urandom), $urandom_range(0, 15), $urandom_range(0, 15),
                   rand_value(), 1'($urandom)));
    repeat ($urandom_range(0, 8))
      send_item(mk(MODE_MATRIX, pick_index(rows), pick_index(cols), rand_value(),
                   1'($urandom)));
    for (int j = 0; j < cols; j++) begin
      if (j < cols - 1 && $urandom_range(0, 7) == 0) continue;
      send_item(mk(MODE_VECTOR, $urandom_range(0, 15), j, rand_value(),
                   (j == cols - 1) || ($urandom_range(0, 19) == 0)));
      if (cols < MAX_DIM && $urandom_range(0, 9) == 0)
        send_item(mk(MODE_VECTOR, $urandom_range(0, 15), $urandom_range(cols, 15),
                     rand_value(), 1'($urandom)));
    end
  endtask

  initial begin
    bit [CFG_W-1:0] rows_cfg [8];
    bit [CFG_W-1:0] cols_cfg [8];
    int             idle_cfg [3];
    int             phase_end;
    rows_cfg    = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd5, 5'd2, 5'd4};
    cols_cfg    = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd4, 5'd2, 5'd3, 5'd5};
    idle_cfg    = '{0, 75, 24};
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_ROW_COUNT;
    cfg_data    = '0;
    idle_pct    = 0;
    items_done  = 0;
    cycle_count = 0;
    sb          = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset sizes, cleared store: sixteen zero products
    send_item(mk(MODE_VECTOR, 15, 15, 32'h7FFF_FFFF, 1'b1));
    wait_idle();
    set_sizes(5'd3, 5'd2);
    send_item(mk(MODE_MATRIX, 0, 0, 32'h7FFF_FFFF, 1'b0));
    send_item(mk(MODE_MATRIX, 0, 1, 32'h7FFF_FFFF, 1'b0));
    send_item(mk(MODE_MATRIX, 1, 0, 32'h8000_0000, 1'b0));
    send_item(mk(MODE_MATRIX, 1, 1, 32'h8000_0000, 1'b0));
    send_item(mk(MODE_MATRIX, 2, 0, 32'h0000_0001, 1'b0));
    send_item(mk(MODE_MATRIX, 2, 1, 32'hFFFF_0000, 1'b1));
    send_item(mk(MODE_MATRIX, 3, 0, 32'h0000_0005, 1'b0));
    send_item(mk(MODE_MATRIX, 0, 2, 32'h0000_0005, 1'b0));
    send_item(mk(MODE_MATRIX, 15, 15, 32'hFFFF_FFFF, 1'b1));
    send_item(mk(MODE_VECTOR, 0, 2, 32'h0001_0000, 1'b1));
    send_item(mk(MODE_VECTOR, 15, 0, 32'h8000_0000, 1'b0));
    send_item(mk(MODE_VECTOR, 0, 1, 32'h8000_0000, 1'b1));
    // rows dropped mid-run keep their sums until the next emission
    send_item(mk(MODE_VECTOR, 0, 0, 32'hFFFF_FFFF, 1'b0));
    wait_idle();
    set_sizes(5'd1, 5'd2);
    send_item(mk(MODE_VECTOR, 0, 0, 32'h0001_0000, 1'b0));
    wait_idle();
    set_sizes(5'd3, 5'd2);
    send_item(mk(MODE_VECTOR, 0, 1, 32'h0000_0001, 1'b1));

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_sizes(rows_cfg[p], cols_cfg[p]);
      idle_pct  = idle_cfg[p % 3];
      phase_end = items_done + 64;
      while (items_done < phase_end) run_sequence();
    end

    wait_idle();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
